// ===== design/pds_pkg.sv =====
package pds_pkg;

  // Line length the buffers are sized for
  localparam int MAX_WIDTH = 1024;

  // Column counter and clamped-width widths
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = COL_W + 1;

  // Line buffers are split four ways on column bits [1:0]
  localparam int NBANK      = 4;
  localparam int BANK_DEPTH = (MAX_WIDTH + NBANK - 1) / NBANK;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Field widths
  localparam int CH_W  = 8;
  localparam int NCH   = 3;
  localparam int PX_W  = CH_W * NCH;
  localparam int NNB   = 4;
  localparam int INW_W = 11;
  localparam int ROW_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  // Register reset values
  localparam logic [INW_W-1:0] IN_WIDTH_RST  = INW_W'(640);
  localparam logic [ROW_W-1:0] IN_HEIGHT_RST = ROW_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH  = 1'b0,
    REG_IN_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [PX_W-1:0] px_t;

  // 3x3 neighbourhood of the current beat, plus step status
  typedef struct packed {
    logic                      emit;
    logic                      last;
    logic [PX_W-1:0]           ctr;
    logic [NNB-1:0][PX_W-1:0]  side;
    logic [NNB-1:0][PX_W-1:0]  diag;
  } win_t;

  // Width register to the width in use: 2 .. MAX_WIDTH
  function automatic logic [WW-1:0] clamp_width(input logic [INW_W-1:0] in_w);
    logic [WW-1:0] w;
    if (int'(in_w) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else if (in_w < INW_W'(2)) begin
      w = WW'(2);
    end else begin
      w = WW'(in_w);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] in_h);
    return (in_h < ROW_W'(2)) ? ROW_W'(2) : in_h;
  endfunction

  // Column in use: a counter at or past the row end acts as the last column
  function automatic logic [COL_W-1:0] eff_col(input logic [COL_W-1:0] col,
                                               input logic [WW-1:0] w);
    logic [COL_W-1:0] c;
    if ({1'b0, col} >= w) begin
      c = COL_W'(w - WW'(1));
    end else begin
      c = col;
    end
    return c;
  endfunction

  // Saturate to one byte
  function automatic logic [CH_W-1:0] sat8(input logic [9:0] v);
    return (v > 10'd255) ? 8'hFF : v[7:0];
  endfunction

  // round(v/3): (v+1)*171 >> 9, exact for v <= 255
  function automatic logic [6:0] div3_round(input logic [CH_W-1:0] v);
    logic [8:0]  x;
    logic [16:0] p;
    x = {1'b0, v} + 9'd1;
    p = 17'(x) * 17'd171;
    return p[15:9];
  endfunction

  // round(v/5): (v+2)*205 >> 10, exact for v <= 255
  function automatic logic [5:0] div5_round(input logic [CH_W-1:0] v);
    logic [8:0]  x;
    logic [16:0] p;
    x = {1'b0, v} + 9'd2;
    p = 17'(x) * 17'd205;
    return p[15:10];
  endfunction

  // round(v/13): (v+6)*79 >> 10, exact for v <= 255
  function automatic logic [4:0] div13_round(input logic [CH_W-1:0] v);
    logic [8:0]  x;
    logic [15:0] p;
    x = {1'b0, v} + 9'd6;
    p = 16'(x) * 16'd79;
    return p[14:10];
  endfunction

endpackage

// ===== design/pds_ram.sv =====
module pds_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write, one registered read; a read of the address being written sees new data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pds_window.sv =====
module pds_window (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  pds_pkg::reg_idx_e                 cfg_idx_i,
  input  logic [pds_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              accept_i,
  input  logic [pds_pkg::PX_W-1:0]          px_i,
  output pds_pkg::win_t                     win_o
);

  localparam int COL_W   = pds_pkg::COL_W;
  localparam int WW      = pds_pkg::WW;
  localparam int NBANK   = pds_pkg::NBANK;
  localparam int BANK_AW = pds_pkg::BANK_AW;
  localparam int PX_W    = pds_pkg::PX_W;
  localparam int ROW_W   = pds_pkg::ROW_W;
  localparam int INW_W   = pds_pkg::INW_W;

  logic [INW_W-1:0]          in_width_q, in_width_d;
  logic [ROW_W-1:0]          in_height_q, in_height_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [2*PX_W-1:0]         left_q, left_d;

  logic [WW-1:0]             w, w_d;
  logic [ROW_W-1:0]          h, r;
  logic [COL_W-1:0]          c, cm, cm2, c_d;
  logic                      emit, c_ge2, c_tail, row_end, lvl_end;
  pds_pkg::px_t              newer, older, lo;
  logic [1:0]                b_c, b_cm, b_cl;

  logic [NBANK-1:0][PX_W-1:0]    rd_prev, rd_prev2, above;
  logic [NBANK-1:0]              we_prev, we_prev2;
  logic [BANK_AW-1:0]            wa_prev;
  logic [NBANK-1:0][BANK_AW-1:0] wa_prev2, ra;
  logic [NBANK-1:0][PX_W-1:0]    wd_prev2;

  // Register writes
  always_comb begin
    in_width_d  = in_width_q;
    in_height_d = in_height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pds_pkg::REG_IN_WIDTH:  in_width_d  = cfg_data_i[INW_W-1:0];
        pds_pkg::REG_IN_HEIGHT: in_height_d = cfg_data_i[ROW_W-1:0];
        default:                in_width_d  = in_width_q;
      endcase
    end
  end

  // Position of the current beat
  assign w      = pds_pkg::clamp_width(in_width_q);
  assign h      = pds_pkg::clamp_height(in_height_q);
  assign c      = pds_pkg::eff_col(col_q, w);
  assign r      = (row_q >= h) ? (h - ROW_W'(1)) : row_q;
  assign cm     = c - COL_W'(1);
  assign cm2    = c - COL_W'(2);
  assign emit   = r[0] & c[0];
  assign c_ge2  = (c >= COL_W'(2));
  assign c_tail = (({1'b0, c} + WW'(2)) >= w);
  assign newer  = left_q[PX_W-1:0];
  assign older  = left_q[2*PX_W-1:PX_W];
  assign lo     = c_ge2 ? older : newer;

  // Counter advance
  assign row_end = (({1'b0, c} + WW'(1)) >= w);
  assign lvl_end = (({1'b0, r} + 17'd1) >= {1'b0, h});

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (accept_i) begin
      left_d = {newer, px_i};
      if (row_end) begin
        col_d = '0;
        row_d = lvl_end ? '0 : (r + ROW_W'(1));
      end else begin
        col_d = c + COL_W'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= pds_pkg::IN_WIDTH_RST;
      in_height_q <= pds_pkg::IN_HEIGHT_RST;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
    end else begin
      in_width_q  <= in_width_d;
      in_height_q <= in_height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
    end
  end

  // Read ahead for the next beat's column, so data is ready when it lands
  assign w_d = pds_pkg::clamp_width(in_width_d);
  assign c_d = pds_pkg::eff_col(col_d, w_d);

  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      ra[b] = BANK_AW'(c_d >> 2)
            - ((2'(b) > c_d[1:0]) ? BANK_AW'(1) : BANK_AW'(0));
    end
  end

  // Even rows fill the upper buffer; odd output steps fill the lower one
  assign wa_prev = BANK_AW'(c >> 2);

  always_comb begin
    for (int b = 0; b < NBANK; b++) begin
      we_prev[b]  = accept_i & ~r[0] & (c[1:0] == 2'(b));
      we_prev2[b] = 1'b0;
      wa_prev2[b] = BANK_AW'(cm >> 2);
      wd_prev2[b] = newer;
      if (accept_i && emit) begin
        if (cm[1:0] == 2'(b)) begin
          we_prev2[b] = 1'b1;
        end else if (c_ge2 && (cm2[1:0] == 2'(b))) begin
          we_prev2[b] = 1'b1;
          wa_prev2[b] = BANK_AW'(cm2 >> 2);
          wd_prev2[b] = older;
        end else if (c_tail && (c[1:0] == 2'(b))) begin
          we_prev2[b] = 1'b1;
          wa_prev2[b] = BANK_AW'(c >> 2);
          wd_prev2[b] = px_i;
        end
      end
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    pds_ram #(
      .WIDTH (PX_W),
      .DEPTH (pds_pkg::BANK_DEPTH)
    ) u_prev (
      .clk_i   (clk_i),
      .we_i    (we_prev[b]),
      .waddr_i (wa_prev),
      .wdata_i (px_i),
      .raddr_i (ra[b]),
      .rdata_o (rd_prev[b])
    );

    pds_ram #(
      .WIDTH (PX_W),
      .DEPTH (pds_pkg::BANK_DEPTH)
    ) u_prev2 (
      .clk_i   (clk_i),
      .we_i    (we_prev2[b]),
      .waddr_i (wa_prev2[b]),
      .wdata_i (wd_prev2[b]),
      .raddr_i (ra[b]),
      .rdata_o (rd_prev2[b])
    );
  end

  // Row above clamps to the even row for the first output row
  assign above = (r >= ROW_W'(3)) ? rd_prev2 : rd_prev;
  assign b_c   = c[1:0];
  assign b_cm  = cm[1:0];
  assign b_cl  = c_ge2 ? cm2[1:0] : cm[1:0];

  // Neighbourhood assembly
  always_comb begin
    win_o.emit    = emit;
    win_o.last    = ((r >> 1) == ((h >> 1) - ROW_W'(1)))
                  && ({1'b0, c >> 1} == ((w >> 1) - WW'(1)));
    win_o.ctr     = rd_prev[b_cm];
    win_o.side[0] = rd_prev[b_cl];
    win_o.side[1] = rd_prev[b_c];
    win_o.side[2] = above[b_cm];
    win_o.side[3] = newer;
    win_o.diag[0] = above[b_cl];
    win_o.diag[1] = px_i;
    win_o.diag[2] = lo;
    win_o.diag[3] = above[b_c];
  end

endmodule

// ===== design/pds_lane.sv =====
module pds_lane (
  input  logic                                     clk_i,
  input  logic                                     ld_s1_i,
  input  logic                                     ld_out_i,
  input  logic [pds_pkg::CH_W-1:0]                 ctr_i,
  input  logic [pds_pkg::NNB-1:0][pds_pkg::CH_W-1:0] side_i,
  input  logic [pds_pkg::NNB-1:0][pds_pkg::CH_W-1:0] diag_i,
  output logic [pds_pkg::CH_W-1:0]                 res_o
);

  localparam int CH_W = pds_pkg::CH_W;

  logic [CH_W-1:0] ctr_q, side_q, side_d, diag_q, diag_d;
  logic [CH_W-1:0] res_q, res_d;
  logic [9:0]      side_sum, diag_sum, term_sum;

  // Stage 1: neighbour sums, clipped to a byte
  assign side_sum = 10'(side_i[0]) + 10'(side_i[1]) + 10'(side_i[2]) + 10'(side_i[3]);
  assign diag_sum = 10'(diag_i[0]) + 10'(diag_i[1]) + 10'(diag_i[2]) + 10'(diag_i[3]);
  assign side_d   = pds_pkg::sat8(side_sum);
  assign diag_d   = pds_pkg::sat8(diag_sum);

  // Stage 2: rounded constant divides, then saturating add
  assign term_sum = 10'(pds_pkg::div3_round(ctr_q))
                  + 10'(pds_pkg::div5_round(side_q))
                  + 10'(pds_pkg::div13_round(diag_q));
  assign res_d    = pds_pkg::sat8(term_sum);

  always_ff @(posedge clk_i) begin
    if (ld_s1_i) begin
      ctr_q  <= ctr_i;
      side_q <= side_d;
      diag_q <= diag_d;
    end
    if (ld_out_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== design/pyramid_downsample_3x3.sv =====
// Odd row/odd column beats pass the stage-1 and output registers. Throughput: one
// input pixel per cycle while not stalled; three channel lanes in parallel, and
// four column banks per line buffer give every read and write its own port. Output
// beats come at a quarter of the input rate; back-pressure stalls input only on
// beats that produce a result. Reset is asynchronous and active low; it returns
// counters, registers and valids to their defaults, no clearing pass.
module pyramid_downsample_3x3 (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pds_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [pds_pkg::CFG_W-1:0]             cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [pds_pkg::PX_W-1:0]              s_axis_tdata,  // chan0, chan1, chan2
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [pds_pkg::PX_W-1:0]              m_axis_tdata,  // out0, out1, out2
  output logic                                  m_axis_tlast   // last_pixel
);

  localparam int NCH  = pds_pkg::NCH;
  localparam int NNB  = pds_pkg::NNB;
  localparam int CH_W = pds_pkg::CH_W;

  pds_pkg::win_t   win;
  logic            accept, ld_s1, ld_out, s1_ready, out_ready;
  logic            s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic            s1_last_q, out_last_q;
  logic [NCH-1:0][CH_W-1:0] res;

  pds_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (pds_pkg::reg_idx_e'(cfg_idx_i)),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .px_i       (s_axis_tdata),
    .win_o      (win)
  );

  // Handshake: beats that emit nothing never wait on the output side
  assign out_ready     = ~out_valid_q | m_axis_tready;
  assign s1_ready      = ~s1_valid_q | out_ready;
  assign s_axis_tready = ~win.emit | s1_ready;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign ld_s1         = accept & win.emit;
  assign ld_out        = out_ready & s1_valid_q;

  assign s1_valid_d  = s1_ready ? ld_s1 : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_s1) begin
      s1_last_q <= win.last;
    end
    if (ld_out) begin
      out_last_q <= s1_last_q;
    end
  end

  // One lane per colour channel
  for (genvar k = 0; k < NCH; k++) begin : g_lane
    logic [NNB-1:0][CH_W-1:0] side_k, diag_k;

    for (genvar j = 0; j < NNB; j++) begin : g_nb
      assign side_k[j] = win.side[j][CH_W*k +: CH_W];
      assign diag_k[j] = win.diag[j][CH_W*k +: CH_W];
    end

    pds_lane u_lane (
      .clk_i    (clk_i),
      .ld_s1_i  (ld_s1),
      .ld_out_i (ld_out),
      .ctr_i    (win.ctr[CH_W*k +: CH_W]),
      .side_i   (side_k),
      .diag_i   (diag_k),
      .res_o    (res[k])
    );
  end

  // Merge lanes into the output beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res;
  assign m_axis_tlast  = out_last_q;

endmodule
